FILE: sv/ilir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilir_pkg: shared types and constants for the indexed list block
// Holds the store depth, derived widths, operation and status codes, and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ilir_pkg;

  // Store depth and derived widths
  localparam int DEPTH   = 32;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Operation codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_DUMP   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOPOS = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic             ins_wr;
    logic             rm_wr;
    logic             load_stat;
    logic [1:0]       stat;
    logic             load_entry;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic rm_ok;
    logic is_last;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: sv/indexed_list_insert_remove.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_remove: ordered list with insert/remove at an index
// Usage:
//   Input channel (in_valid/in_stall) carries mode, position and value.
//   Insert places value after position entries (beyond count appends);
//   remove deletes the 1-based entry; dump streams all entries in order.
//   Result channel (out_valid/out_stall) carries status, entry_value,
//   entry_valid and last; last marks the final result of an item.
//   Insert and remove update the whole cell row in the accept cycle; the
//   status result appears in the cycle after the transfer in. With the output
//   taken every cycle a new insert/remove is accepted every cycle.
//   A dump enters the dump state, then loads one entry per cycle while the
//   output is free; input is stalled until the last entry is loaded.
//   A stall on the output holds the result register and stalls the input.
//   Reset (synchronous, active low) empties the list and drops any result.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          in_mode,
  input  wire logic [ilir_pkg::POS_W-1:0]          in_position,
  input  wire logic signed [ilir_pkg::DATA_W-1:0]  in_value,
  output logic                                     out_valid,
  input  wire                                      out_stall,
  output logic [1:0]                               out_status,
  output logic signed [ilir_pkg::DATA_W-1:0]       out_entry_value,
  output logic                                     out_entry_valid,
  output logic                                     out_last
);
  import ilir_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Control
  ilir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (in_mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Cell store and result register
  ilir_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .position        (in_position),
    .value           (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_entry_valid (out_entry_valid),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

FILE: sv/ilir_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilir_dp: shifting cell store, entry count and result register
// Every cell updates in parallel, so an insert or remove completes at once.
// A dump reads one cell per cycle, at the controller's index, unless stalled.
// ----------------------------------------------------------------------------
module ilir_dp (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire logic [ilir_pkg::POS_W-1:0]  position,
  input  wire logic signed [ilir_pkg::DATA_W-1:0] value,
  input  wire ilir_pkg::dp_cmd_t       cmd,
  output ilir_pkg::dp_stat_t           stat,
  output logic [1:0]                   out_status,
  output logic signed [ilir_pkg::DATA_W-1:0] out_entry_value,
  output logic                         out_entry_valid,
  output logic                         out_last
);
  import ilir_pkg::*;

  logic [DATA_W-1:0] cells_r [DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CMP_W-1:0]  pos_x, cnt_x, ins_at, rm_at;

  logic [1:0]        status_r, status_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic              evalid_r, evalid_nxt;
  logic              last_r, last_nxt;

  // Position compares at a common width
  assign pos_x  = CMP_W'(position);
  assign cnt_x  = CMP_W'(count_r);
  assign ins_at = (pos_x > cnt_x) ? cnt_x : pos_x;
  assign rm_at  = pos_x - CMP_W'(1);

  // Status back to the controller
  assign stat.full    = (count_r == CNT_W'(DEPTH));
  assign stat.empty   = (count_r == '0);
  assign stat.rm_ok   = (pos_x != '0) && (pos_x <= cnt_x);
  assign stat.is_last = ((CNT_W'(cmd.idx) + CNT_W'(1)) == count_r);

  // Cell row: shift right of the insert point, shift left from removed slot
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.ins_wr) begin
        if (CMP_W'(i) == ins_at) begin
          cells_r[i] <= value;
        end else if (i > 0 && CMP_W'(i) > ins_at) begin
          cells_r[i] <= cells_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.rm_wr) begin
        if (i < DEPTH - 1 && CMP_W'(i) >= rm_at) begin
          cells_r[i] <= cells_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_wr) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rm_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result payload register
  always_comb begin
    status_nxt = status_r;
    value_nxt  = value_r;
    evalid_nxt = evalid_r;
    last_nxt   = last_r;
    if (cmd.load_stat) begin
      status_nxt = cmd.stat;
      value_nxt  = '0;
      evalid_nxt = 1'b0;
      last_nxt   = 1'b1;
    end else if (cmd.load_entry) begin
      status_nxt = ST_DONE;
      value_nxt  = cells_r[cmd.idx];
      evalid_nxt = 1'b1;
      last_nxt   = stat.is_last;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    value_r  <= value_nxt;
    evalid_r <= evalid_nxt;
    last_r   <= last_nxt;
  end

  assign out_status      = status_r;
  assign out_entry_value = value_r;
  assign out_entry_valid = evalid_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

FILE: sv/ilir_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilir_ctrl: handshake control and dump sequencer
// Decodes each accepted item into datapath commands and steps the dump
// index one entry per output transfer.
// ----------------------------------------------------------------------------
module ilir_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  output logic                    out_valid,
  input  wire                     out_stall,
  input  wire ilir_pkg::dp_stat_t stat,
  output ilir_pkg::dp_cmd_t       cmd
);
  import ilir_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic             state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic             out_free, accept;

  // Output register can take a new result
  assign out_free = !ovalid_r || !out_stall;
  assign in_stall = (state_r == S_DUMP) || !out_free;
  assign accept   = in_valid && !in_stall;

  // Decode and sequence
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cmd            = '0;
    cmd.idx        = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_INSERT: begin
              cmd.ins_wr    = !stat.full;
              cmd.load_stat = 1'b1;
              cmd.stat      = stat.full ? ST_FULL : ST_DONE;
            end
            MODE_REMOVE: begin
              cmd.rm_wr     = stat.rm_ok;
              cmd.load_stat = 1'b1;
              cmd.stat      = stat.rm_ok ? ST_DONE : ST_NOPOS;
            end
            MODE_DUMP: begin
              if (stat.empty) begin
                cmd.load_stat = 1'b1;
                cmd.stat      = ST_DONE;
              end else begin
                state_nxt = S_DUMP;
                idx_nxt   = '0;
              end
            end
            default: begin
              cmd.load_stat = 1'b1;
              cmd.stat      = ST_NOPOS;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd.load_entry = 1'b1;
          idx_nxt        = idx_r + IDX_W'(1);
          if (stat.is_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    ovalid_nxt = cmd.load_stat || cmd.load_entry || (ovalid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

endmodule
`default_nettype wire
